// ===== src/timed_blind_position_tilt_tracker_defines.svh =====
// Assertion macros shared by the tracker RTL.
// In synthesis builds the macros expand to nothing.
`ifndef TIMED_BLIND_POSITION_TILT_TRACKER_DEFINES_SVH
`define TIMED_BLIND_POSITION_TILT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check that is ignored while reset is high.
`define TBPT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// Clocked check that also holds during reset.
`define TBPT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define TBPT_ASSERT(label, clk, rst, prop, msg)
`define TBPT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/tbpt_pkg.sv =====
`default_nettype none

package tbpt_pkg;

  // Field widths.
  localparam int CMD_W     = 3;
  localparam int MS_W      = 16;
  localparam int VAL_W     = 16;
  localparam int DUR_W     = 20;
  localparam int CFG_IDX_W = 3;

  // Internal fixed-point precision of position and tilt.
  localparam int FRAC_BITS = 16;
  localparam logic [FRAC_BITS-1:0] FULL      = '1;
  localparam logic [FRAC_BITS-1:0] POS_RESET = FRAC_BITS'(1) << (FRAC_BITS - 1);

  // Divider sizing.
  localparam int DIV_NW = MS_W + FRAC_BITS;
  localparam int DIV_CW = $clog2(FRAC_BITS);

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(30000);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOGGLE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_POS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_TLT = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DUR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DUR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_DUR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDSTOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL    = 3'd4;

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_OPEN  = 2'd1,
    M_CLOSE = 2'd2
  } motion_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_OPEN  = 2'd1,
    EV_CLOSE = 2'd2,
    EV_STOP  = 2'd3
  } drive_ev_t;

  // Scale a 16-bit fraction to FRAC_BITS by bit replication or truncation.
  function automatic logic [FRAC_BITS-1:0] widen(input logic [VAL_W-1:0] v);
    logic [FRAC_BITS-1:0] r;
    for (int j = 0; j < FRAC_BITS; j++) begin
      r[FRAC_BITS-1-j] = v[VAL_W-1-((j < VAL_W) ? j : j - VAL_W)];
    end
    return r;
  endfunction

  // Scale a FRAC_BITS fraction back to 16 bits the same way.
  function automatic logic [VAL_W-1:0] narrow(input logic [FRAC_BITS-1:0] p);
    logic [VAL_W-1:0] r;
    for (int j = 0; j < VAL_W; j++) begin
      r[VAL_W-1-j] = p[FRAC_BITS-1-((j < FRAC_BITS) ? j : j - FRAC_BITS)];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/tbpt_if.sv =====
`default_nettype none

// Command channel.
interface tbpt_cmd_if;
  import tbpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [MS_W-1:0]  elapsed_ms;
  logic [VAL_W-1:0] value;

  modport source (output valid, command, elapsed_ms, value, input ready);
  modport sink   (input valid, command, elapsed_ms, value, output ready);
endinterface

// Result channel.
interface tbpt_res_if;
  import tbpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [VAL_W-1:0] position_now;
  logic [VAL_W-1:0] tilt_now;
  logic [1:0]       drive_event;
  logic             publish;

  modport source (output valid, operation, position_now, tilt_now, drive_event, publish,
                  input ready);
  modport sink   (input valid, operation, position_now, tilt_now, drive_event, publish,
                  output ready);
endinterface

`default_nettype wire

// ===== src/tbpt_div.sv =====
`default_nettype none

// Computes min(ms * FULL / dur, FULL) with a restoring divider, one
// quotient bit per cycle. A zero duration counts as one millisecond.
module tbpt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tbpt_pkg::MS_W-1:0]     ms,
  input  logic [tbpt_pkg::DUR_W-1:0]    dur,
  output logic                          done,
  output logic [tbpt_pkg::FRAC_BITS-1:0] quot
);
  import tbpt_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_RUN
  } dstate_t;

  dstate_t               st;
  logic [DIV_NW-1:0]     num;
  logic [DUR_W-1:0]      dvs;
  logic [DUR_W-1:0]      rem;
  logic [FRAC_BITS-1:0]  low;
  logic [DIV_CW-1:0]     cnt;
  logic [DUR_W:0]        trial;
  logic                  fits;
  logic                  sat;

  assign trial = {rem, low[FRAC_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};
  // The quotient overflows FRAC_BITS when num >= dvs * 2^FRAC_BITS.
  assign sat   = {{(DUR_W - MS_W){1'b0}}, num} >= {dvs, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        D_IDLE: begin
          if (start) begin
            num <= (DIV_NW'(ms) << FRAC_BITS) - DIV_NW'(ms);
            dvs <= (dur == '0) ? DUR_W'(1) : dur;
            st  <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (sat) begin
            quot <= FULL;
            done <= 1'b1;
            st   <= D_IDLE;
          end else begin
            rem <= DUR_W'(num[DIV_NW-1:FRAC_BITS]);
            low <= num[FRAC_BITS-1:0];
            cnt <= DIV_CW'(FRAC_BITS - 1);
            st  <= D_RUN;
          end
        end
        D_RUN: begin
          if (fits) begin
            rem  <= DUR_W'(trial - {1'b0, dvs});
            quot <= {quot[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem  <= trial[DUR_W-1:0];
            quot <= {quot[FRAC_BITS-2:0], 1'b0};
          end
          low <= low << 1;
          if (cnt == '0) begin
            done <= 1'b1;
            st   <= D_IDLE;
          end else begin
            cnt <= cnt - DIV_CW'(1);
          end
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/timed_blind_position_tilt_tracker.sv =====
// Run-time position and slat tilt estimator for a motorized venetian blind.
// Each transaction on the command channel (tick, stop, toggle, set position,
// set tilt) yields exactly one transaction on the result channel with the
// motion after the command, the position and tilt estimates, the motor drive
// event fired and a publish flag. A tick that arrives while the motor runs
// waits on the serial divider, which scales the elapsed time by the travel
// or tilt duration one quotient bit per cycle, or skips its bit loop when
// the step saturates at full travel. The command channel is not ready while
// a command is in work, but a finished result may wait in the output
// register while the next command is taken. The user must write durations
// and options on the configuration port only while no command is in work;
// the block itself does not enforce this.

`default_nettype none
`include "timed_blind_position_tilt_tracker_defines.svh"

module timed_blind_position_tilt_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbpt_pkg::DUR_W-1:0]    cfg_data,
  tbpt_cmd_if.sink                      cmd,
  tbpt_res_if.source                    res
);
  import tbpt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    motion_t   motion;
    motion_t   last;
    drive_ev_t ev;
  } drive_t;

  // Configuration registers.
  logic [DUR_W-1:0] open_dur;
  logic [DUR_W-1:0] close_dur;
  logic [DUR_W-1:0] tilt_dur;
  logic             has_endstop;
  logic             manual_ctl;

  // Tracker state.
  motion_t              motion;
  motion_t              last_dir;
  logic [FRAC_BITS-1:0] position;
  logic [FRAC_BITS-1:0] tilt;
  logic [FRAC_BITS-1:0] target_pos;
  logic [FRAC_BITS-1:0] target_tilt;

  // The command in work.
  state_t               st;
  logic [CMD_W-1:0]     cmd_q;
  logic [FRAC_BITS-1:0] val_q;
  logic                 tilting_q;
  logic [FRAC_BITS-1:0] amt;

  // Output register.
  logic                 out_valid;
  motion_t              out_operation;
  logic [VAL_W-1:0]     out_position;
  logic [VAL_W-1:0]     out_tilt;
  drive_ev_t            out_event;
  logic                 out_publish;

  // Divider hookup.
  logic                 div_start;
  logic [DUR_W-1:0]     div_dur;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_q;

  logic accept;
  logic tilt_sel;
  logic commit;

  // Next values produced when a command is finished.
  motion_t              motion_next;
  motion_t              last_dir_next;
  logic [FRAC_BITS-1:0] position_next;
  logic [FRAC_BITS-1:0] tilt_next;
  logic [FRAC_BITS-1:0] target_pos_next;
  logic [FRAC_BITS-1:0] target_tilt_next;
  drive_ev_t            event_next;
  logic                 publish_next;

  // Switching the motor: restarting in the direction already running fires
  // nothing, any other request fires the matching drive event.
  function automatic drive_t drive(input motion_t dir, input motion_t cur,
                                   input motion_t last);
    drive_t d;
    d.motion = cur;
    d.last   = last;
    d.ev     = EV_NONE;
    if (!(dir == cur && dir != M_IDLE)) begin
      if (dir != M_IDLE) begin
        d.last = dir;
      end
      d.motion = dir;
      case (dir)
        M_OPEN:  d.ev = EV_OPEN;
        M_CLOSE: d.ev = EV_CLOSE;
        default: d.ev = EV_STOP;
      endcase
    end
    return d;
  endfunction

  // Saturating move of a fraction by one step.
  function automatic logic [FRAC_BITS-1:0] move(input logic [FRAC_BITS-1:0] v,
                                                input logic [FRAC_BITS-1:0] a,
                                                input logic up);
    logic [FRAC_BITS:0] sum;
    logic [FRAC_BITS-1:0] r;
    sum = {1'b0, v} + {1'b0, a};
    if (up) begin
      r = (sum > {1'b0, FULL}) ? FULL : sum[FRAC_BITS-1:0];
    end else begin
      r = (a > v) ? '0 : v - a;
    end
    return r;
  endfunction

  assign cmd.ready = (st == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // On a tick while running, the tilt moves first until it reaches its
  // target; only then does the position move. The choice is made from the
  // state at acceptance, which nothing else changes before the result.
  assign tilt_sel = (tilt_dur != '0) &&
                    ((motion == M_OPEN) ? (tilt < target_tilt) : (tilt > target_tilt));

  assign div_start = accept && (cmd.command == CMD_TICK) && (motion != M_IDLE);
  assign div_dur   = tilt_sel ? tilt_dur : ((motion == M_OPEN) ? open_dur : close_dur);

  tbpt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .ms    (cmd.elapsed_ms),
    .dur   (div_dur),
    .done  (div_done),
    .quot  (div_q)
  );

  // The result is written once the output register is free or being taken.
  assign commit = (st == S_FIN) && (!out_valid || res.ready);

  always_comb begin
    drive_t d;
    logic   up;
    logic   at_end;
    logic   reach;
    motion_t op;

    motion_next      = motion;
    last_dir_next    = last_dir;
    position_next    = position;
    tilt_next        = tilt;
    target_pos_next  = target_pos;
    target_tilt_next = target_tilt;
    event_next       = EV_NONE;
    publish_next     = 1'b0;
    d                = '0;
    up               = (motion == M_OPEN);
    at_end           = (val_q == '0) || (val_q == FULL);
    reach            = 1'b0;
    op               = M_IDLE;

    case (cmd_q)
      CMD_TICK: begin
        if (motion != M_IDLE) begin
          if (tilting_q) begin
            tilt_next = move(tilt, amt, up);
          end else begin
            position_next = move(position, amt, up);
          end
          if (up) begin
            reach = (position_next >= target_pos) &&
                    ((tilt_dur == '0) || (tilt_next >= target_tilt));
          end else begin
            reach = (position_next <= target_pos) &&
                    ((tilt_dur == '0) || (tilt_next <= target_tilt));
          end
          if (reach) begin
            // A motor with its own endstop stops by itself at either end.
            if (has_endstop && ((target_pos == FULL) || (target_pos == '0))) begin
              motion_next = M_IDLE;
            end else begin
              d             = drive(M_IDLE, motion, last_dir);
              motion_next   = d.motion;
              last_dir_next = d.last;
              event_next    = d.ev;
            end
            publish_next = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        d             = drive(M_IDLE, motion, last_dir);
        motion_next   = d.motion;
        last_dir_next = d.last;
        event_next    = d.ev;
        publish_next  = 1'b1;
      end
      CMD_TOGGLE: begin
        if (motion != M_IDLE) begin
          d            = drive(M_IDLE, motion, last_dir);
          publish_next = 1'b1;
        end else if ((position == '0) || (last_dir == M_CLOSE)) begin
          target_pos_next  = FULL;
          target_tilt_next = FULL;
          d                = drive(M_OPEN, motion, last_dir);
        end else begin
          target_pos_next  = '0;
          target_tilt_next = '0;
          d                = drive(M_CLOSE, motion, last_dir);
        end
        motion_next   = d.motion;
        last_dir_next = d.last;
        event_next    = d.ev;
      end
      CMD_SET_POS: begin
        if (val_q == position) begin
          op = (val_q == '0) ? M_CLOSE : M_OPEN;
          // With a manual switch the blind may sit at the opposite end, so
          // assume it does and run toward the request.
          if (manual_ctl && at_end) begin
            position_next    = (val_q == '0) ? FULL : '0;
            target_pos_next  = val_q;
            target_tilt_next = (val_q == '0) ? '0 : FULL;
            d                = drive(op, motion_next, last_dir_next);
            motion_next      = d.motion;
            last_dir_next    = d.last;
            if (d.ev != EV_NONE) begin
              event_next = d.ev;
            end
          end
          // With an endstop the motor is driven into the end again.
          if (has_endstop && at_end) begin
            target_pos_next  = val_q;
            target_tilt_next = (val_q == '0) ? '0 : FULL;
            d                = drive(op, motion_next, last_dir_next);
            motion_next      = d.motion;
            last_dir_next    = d.last;
            if (d.ev != EV_NONE) begin
              event_next = d.ev;
            end
          end
        end else begin
          op = (val_q < position) ? M_CLOSE : M_OPEN;
          if (manual_ctl && at_end) begin
            position_next = (val_q == '0) ? FULL : '0;
          end
          target_pos_next  = val_q;
          target_tilt_next = (val_q == '0) ? '0 : FULL;
          d                = drive(op, motion, last_dir);
          motion_next      = d.motion;
          last_dir_next    = d.last;
          event_next       = d.ev;
        end
      end
      CMD_SET_TLT: begin
        if (val_q != tilt) begin
          op               = (val_q < tilt) ? M_CLOSE : M_OPEN;
          target_pos_next  = position;
          target_tilt_next = val_q;
          d                = drive(op, motion, last_dir);
          motion_next      = d.motion;
          last_dir_next    = d.last;
          event_next       = d.ev;
        end
      end
      default: begin
        // Unknown commands leave everything as it is.
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_dur    <= DUR_RESET;
      close_dur   <= DUR_RESET;
      tilt_dur    <= '0;
      has_endstop <= 1'b0;
      manual_ctl  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPEN_DUR:  open_dur    <= cfg_data;
        CFG_CLOSE_DUR: close_dur   <= cfg_data;
        CFG_TILT_DUR:  tilt_dur    <= cfg_data;
        CFG_ENDSTOP:   has_endstop <= cfg_data[0];
        CFG_MANUAL:    manual_ctl  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, tracker state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      out_valid   <= 1'b0;
      motion      <= M_IDLE;
      last_dir    <= M_IDLE;
      position    <= POS_RESET;
      tilt        <= '0;
      target_pos  <= '0;
      target_tilt <= '0;
    end else begin
      // A new result replaces one that is being taken in the same cycle.
      if (commit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            cmd_q     <= cmd.command;
            val_q     <= widen(cmd.value);
            tilting_q <= tilt_sel;
            st        <= div_start ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            amt <= div_q;
            st  <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit) begin
            motion        <= motion_next;
            last_dir      <= last_dir_next;
            position      <= position_next;
            tilt          <= tilt_next;
            target_pos    <= target_pos_next;
            target_tilt   <= target_tilt_next;
            out_operation <= motion_next;
            out_position  <= narrow(position_next);
            out_tilt      <= narrow(tilt_next);
            out_event     <= event_next;
            out_publish   <= publish_next;
            st            <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.operation    = out_operation;
  assign res.position_now = out_position;
  assign res.tilt_now     = out_tilt;
  assign res.drive_event  = out_event;
  assign res.publish      = out_publish;

  // A command blocks the channel until its result is written.
  `TBPT_ASSERT(a_one_in_work, clk, rst, accept |=> !cmd.ready, "command taken while busy")
  // The divider only finishes for a tick that is waiting on it.
  `TBPT_ASSERT(a_div_in_div, clk, rst, div_done |-> (st == S_DIV), "stray divider result")
  // Every publish reports a blind that has come to rest.
  `TBPT_ASSERT(a_pub_idle, clk, rst, (out_valid && out_publish) |-> (out_operation == M_IDLE),
               "publish while moving")
  // An open drive always leaves the blind opening.
  `TBPT_ASSERT(a_open_ev, clk, rst,
               (out_valid && (out_event == EV_OPEN)) |-> (out_operation == M_OPEN),
               "open event without opening")

endmodule

`default_nettype wire
